@@ rtl/core/psc_pkg.sv @@
// Shared types and constants for the packed string compare pipeline.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int NumElem     = 16;
  localparam int NumWordElem = NumElem / 2;
  localparam int ElemW       = 16;
  localparam int LenW        = $clog2(NumElem + 1);
  localparam int IdxW        = $clog2(NumElem);
  localparam int OperandW    = 128;

  typedef enum logic [1:0] {
    AggEqualAny     = 2'd0,
    AggRanges       = 2'd1,
    AggEqualEach    = 2'd2,
    AggEqualOrdered = 2'd3
  } agg_e;

  typedef enum logic [1:0] {
    PolPositive  = 2'd0,
    PolNegative  = 2'd1,
    PolMaskedPos = 2'd2,
    PolMaskedNeg = 2'd3
  } pol_e;

  typedef logic [ElemW-1:0]   elem_t;
  typedef elem_t [NumElem-1:0] keys_t;
  typedef logic [NumElem-1:0] row_t;
  typedef row_t [NumElem-1:0] matrix_t;

  typedef struct packed {
    logic            words;
    agg_e            agg;
    pol_e            pol;
    logic            sel;
    logic            mask_mode;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    keys_t keys_a;
    keys_t keys_b;
  } prep_t;

  typedef struct packed {
    logic [NumElem-1:0] int_result;
    logic [LenW-1:0]    match_index;
    logic [63:0]        mask_low;
    logic [63:0]        mask_high;
    logic               carry_flag;
    logic               zero_flag;
    logic               sign_flag;
    logic               overflow_flag;
  } res_t;

endpackage

@@ rtl/core/psc_prep.sv @@
// Element unpack, sign bias and effective string lengths.
`timescale 1ns / 1ps

module psc_prep (
  input  logic [1:0]          mode_i,
  input  logic [7:0]          control_i,
  input  logic [63:0]         operand_a_low_i,
  input  logic [63:0]         operand_a_high_i,
  input  logic [63:0]         operand_b_low_i,
  input  logic [63:0]         operand_b_high_i,
  input  logic signed [31:0]  len_a_i,
  input  logic signed [31:0]  len_b_i,
  output psc_pkg::prep_t      prep_o
);

  logic [psc_pkg::OperandW-1:0] op_a, op_b;
  logic                         words, sgn;
  logic [psc_pkg::LenW-1:0]     n;
  psc_pkg::keys_t               raw_a, raw_b;
  psc_pkg::elem_t               bias;
  logic [31:0]                  mag_a, mag_b;
  logic [psc_pkg::LenW-1:0]     imp_a, imp_b, exp_a, exp_b;

  assign op_a  = {operand_a_high_i, operand_a_low_i};
  assign op_b  = {operand_b_high_i, operand_b_low_i};
  assign words = control_i[0];
  assign sgn   = control_i[1];
  assign n     = words ? psc_pkg::LenW'(psc_pkg::NumWordElem)
                       : psc_pkg::LenW'(psc_pkg::NumElem);

  always_comb begin
    for (int i = 0; i < psc_pkg::NumElem; i++) begin
      if (words) begin
        if (i < psc_pkg::NumWordElem) begin
          raw_a[i] = op_a[i*psc_pkg::ElemW +: psc_pkg::ElemW];
          raw_b[i] = op_b[i*psc_pkg::ElemW +: psc_pkg::ElemW];
        end else begin
          raw_a[i] = '0;
          raw_b[i] = '0;
        end
      end else begin
        raw_a[i] = {8'h00, op_a[i*8 +: 8]};
        raw_b[i] = {8'h00, op_b[i*8 +: 8]};
      end
    end
  end

  // signed compare becomes unsigned after flipping the element sign bit
  always_comb begin
    bias = '0;
    if (sgn) begin
      bias = words ? psc_pkg::elem_t'(16'h8000) : psc_pkg::elem_t'(16'h0080);
    end
  end

  // implicit length: index of first null element
  always_comb begin
    imp_a = n;
    imp_b = n;
    for (int i = psc_pkg::NumElem - 1; i >= 0; i--) begin
      if (psc_pkg::LenW'(i) < n && raw_a[i] == '0) imp_a = psc_pkg::LenW'(i);
      if (psc_pkg::LenW'(i) < n && raw_b[i] == '0) imp_b = psc_pkg::LenW'(i);
    end
  end

  // explicit length: magnitude saturated to the element count
  assign mag_a = len_a_i[31] ? (32'd0 - 32'(len_a_i)) : 32'(len_a_i);
  assign mag_b = len_b_i[31] ? (32'd0 - 32'(len_b_i)) : 32'(len_b_i);
  assign exp_a = (mag_a > 32'(n)) ? n : mag_a[psc_pkg::LenW-1:0];
  assign exp_b = (mag_b > 32'(n)) ? n : mag_b[psc_pkg::LenW-1:0];

  always_comb begin
    for (int i = 0; i < psc_pkg::NumElem; i++) begin
      prep_o.keys_a[i] = raw_a[i] ^ bias;
      prep_o.keys_b[i] = raw_b[i] ^ bias;
    end
    prep_o.ctl.words     = words;
    prep_o.ctl.agg       = psc_pkg::agg_e'(control_i[3:2]);
    prep_o.ctl.pol       = psc_pkg::pol_e'(control_i[5:4]);
    prep_o.ctl.sel       = control_i[6];
    prep_o.ctl.mask_mode = mode_i[0];
    prep_o.ctl.len_a     = mode_i[1] ? imp_a : exp_a;
    prep_o.ctl.len_b     = mode_i[1] ? imp_b : exp_b;
  end

endmodule

@@ rtl/core/psc_lane.sv @@
// One compare lane: a searched element against every pattern element.
`timescale 1ns / 1ps

module psc_lane (
  input  logic [psc_pkg::IdxW-1:0] lane_idx_i,
  input  psc_pkg::elem_t           b_key_i,
  input  psc_pkg::keys_t           a_keys_i,
  input  psc_pkg::ctl_t            ctl_i,
  output psc_pkg::row_t            row_o
);

  logic b_valid;
  logic a_valid;
  logic hit;

  assign b_valid = {1'b0, lane_idx_i} < ctl_i.len_b;

  always_comb begin
    a_valid = 1'b0;
    hit     = 1'b0;
    for (int i = 0; i < psc_pkg::NumElem; i++) begin
      a_valid = psc_pkg::LenW'(i) < ctl_i.len_a;
      if (ctl_i.agg == psc_pkg::AggRanges) begin
        // even entries are lower bounds, odd entries upper bounds
        hit = (i % 2 == 1) ? (b_key_i <= a_keys_i[i]) : (b_key_i >= a_keys_i[i]);
      end else begin
        hit = (b_key_i == a_keys_i[i]);
      end
      // override rules for elements past the string end
      if (a_valid && b_valid) begin
        row_o[i] = hit;
      end else if (a_valid) begin
        row_o[i] = 1'b0;
      end else if (b_valid) begin
        row_o[i] = (ctl_i.agg == psc_pkg::AggEqualOrdered);
      end else begin
        row_o[i] = (ctl_i.agg == psc_pkg::AggEqualEach) ||
                   (ctl_i.agg == psc_pkg::AggEqualOrdered);
      end
    end
  end

endmodule

@@ rtl/core/psc_merge.sv @@
// Aggregation of lane rows, polarity, index select, mask expand and flags.
`timescale 1ns / 1ps

module psc_merge (
  input  psc_pkg::matrix_t rows_i,
  input  psc_pkg::ctl_t    ctl_i,
  output psc_pkg::res_t    res_o
);

  logic [psc_pkg::LenW-1:0]     n;
  psc_pkg::row_t                valid_elems;
  psc_pkg::row_t                res1, res2, len_mask;
  logic [psc_pkg::NumElem:0]    len_mask_wide;
  logic [psc_pkg::LenW-1:0]     idx;
  logic [psc_pkg::OperandW-1:0] mask;
  logic                         bit_any, bit_rng, bit_ord;

  assign n           = ctl_i.words ? psc_pkg::LenW'(psc_pkg::NumWordElem)
                                   : psc_pkg::LenW'(psc_pkg::NumElem);
  assign valid_elems = ctl_i.words ? psc_pkg::row_t'({psc_pkg::NumWordElem{1'b1}})
                                   : '1;

  always_comb begin
    res1 = '0;
    for (int j = 0; j < psc_pkg::NumElem; j++) begin
      bit_any = |(rows_i[j] & valid_elems);
      bit_rng = 1'b0;
      for (int p = 0; p < psc_pkg::NumWordElem; p++) begin
        bit_rng = bit_rng | (rows_i[j][2*p] & rows_i[j][2*p+1] & valid_elems[2*p+1]);
      end
      // ordered: diagonal from (j,0) down to the last valid element
      bit_ord = 1'b1;
      for (int k = 0; k < psc_pkg::NumElem; k++) begin
        if (j + k < psc_pkg::NumElem) begin
          if (psc_pkg::LenW'(j + k) < n) bit_ord = bit_ord & rows_i[j+k][k];
        end
      end
      unique case (ctl_i.agg)
        psc_pkg::AggEqualAny:     res1[j] = bit_any;
        psc_pkg::AggRanges:       res1[j] = bit_rng;
        psc_pkg::AggEqualEach:    res1[j] = rows_i[j][j];
        psc_pkg::AggEqualOrdered: res1[j] = bit_ord;
        default:                  res1[j] = 1'b0;
      endcase
      res1[j] = res1[j] & valid_elems[j];
    end
  end

  assign len_mask_wide = ({{psc_pkg::NumElem{1'b0}}, 1'b1} << ctl_i.len_b)
                       - (psc_pkg::NumElem + 1)'(1);
  assign len_mask      = len_mask_wide[psc_pkg::NumElem-1:0];

  always_comb begin
    unique case (ctl_i.pol)
      psc_pkg::PolNegative:  res2 = ~res1 & valid_elems;
      psc_pkg::PolMaskedNeg: res2 = (res1 ^ len_mask) & valid_elems;
      default:               res2 = res1;
    endcase
  end

  always_comb begin
    idx = n;
    if (ctl_i.sel) begin
      for (int i = 0; i < psc_pkg::NumElem; i++) begin
        if (res2[i]) idx = psc_pkg::LenW'(i);
      end
    end else begin
      for (int i = psc_pkg::NumElem - 1; i >= 0; i--) begin
        if (res2[i]) idx = psc_pkg::LenW'(i);
      end
    end
  end

  always_comb begin
    mask = '0;
    if (ctl_i.sel) begin
      for (int i = 0; i < psc_pkg::NumElem; i++) begin
        if (ctl_i.words) begin
          if (i < psc_pkg::NumWordElem) mask[i*psc_pkg::ElemW +: psc_pkg::ElemW] = {psc_pkg::ElemW{res2[i]}};
        end else begin
          mask[i*8 +: 8] = {8{res2[i]}};
        end
      end
    end else begin
      mask = psc_pkg::OperandW'(res2);
    end
  end

  always_comb begin
    res_o.int_result    = res2;
    res_o.match_index   = ctl_i.mask_mode ? '0 : idx;
    res_o.mask_low      = ctl_i.mask_mode ? mask[63:0] : '0;
    res_o.mask_high     = ctl_i.mask_mode ? mask[127:64] : '0;
    res_o.carry_flag    = |res2;
    res_o.zero_flag     = ctl_i.len_b < n;
    res_o.sign_flag     = ctl_i.len_a < n;
    res_o.overflow_flag = res2[0];
  end

endmodule

@@ rtl/core/packed_string_compare.sv @@
// Packed string compare: three-stage pipeline, one request per cycle.
// Path: a request is registered in prep_q, its lane rows in rows_q and its result in res_q, shown with valid_o.
// Throughput: one request every cycle; busy_o stays low, and stage two holds the 16 compare lanes.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
// Reset: asynchronous, active low; clears the stage valid bits, no result is pending after it.
`timescale 1ns / 1ps

module packed_string_compare (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         control_i,
  input  logic [63:0]        operand_a_low_i,
  input  logic [63:0]        operand_a_high_i,
  input  logic [63:0]        operand_b_low_i,
  input  logic [63:0]        operand_b_high_i,
  input  logic signed [31:0] len_a_i,
  input  logic signed [31:0] len_b_i,
  output logic               valid_o,
  output logic [15:0]        int_result_o,
  output logic [4:0]         match_index_o,
  output logic [63:0]        mask_low_o,
  output logic [63:0]        mask_high_o,
  output logic               carry_flag_o,
  output logic               zero_flag_o,
  output logic               sign_flag_o,
  output logic               overflow_flag_o
);

  psc_pkg::prep_t   prep_d, prep_q;
  psc_pkg::matrix_t rows_d, rows_q;
  psc_pkg::ctl_t    ctl_q;
  psc_pkg::res_t    res_d, res_q;
  logic             v1_q, v2_q, v3_q;

  assign busy_o = 1'b0;

  psc_prep u_prep (
    .mode_i           (mode_i),
    .control_i        (control_i),
    .operand_a_low_i  (operand_a_low_i),
    .operand_a_high_i (operand_a_high_i),
    .operand_b_low_i  (operand_b_low_i),
    .operand_b_high_i (operand_b_high_i),
    .len_a_i          (len_a_i),
    .len_b_i          (len_b_i),
    .prep_o           (prep_d)
  );

  for (genvar j = 0; j < psc_pkg::NumElem; j++) begin : g_lane
    psc_lane u_lane (
      .lane_idx_i (psc_pkg::IdxW'(j)),
      .b_key_i    (prep_q.keys_b[j]),
      .a_keys_i   (prep_q.keys_a),
      .ctl_i      (prep_q.ctl),
      .row_o      (rows_d[j])
    );
  end

  psc_merge u_merge (
    .rows_i (rows_q),
    .ctl_i  (ctl_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      prep_q <= prep_d;
    end
    if (v1_q) begin
      rows_q <= rows_d;
      ctl_q  <= prep_q.ctl;
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o         = v3_q;
  assign int_result_o    = res_q.int_result;
  assign match_index_o   = res_q.match_index;
  assign mask_low_o      = res_q.mask_low;
  assign mask_high_o     = res_q.mask_high;
  assign carry_flag_o    = res_q.carry_flag;
  assign zero_flag_o     = res_q.zero_flag;
  assign sign_flag_o     = res_q.sign_flag;
  assign overflow_flag_o = res_q.overflow_flag;

  // every request comes out on valid_o after passing prep_q, rows_q and res_q
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##3 valid_o)
    else $error("request did not produce a result after three cycles");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> match_index_o <= 5'd16)
    else $error("match index beyond element count");

  // a nonzero mask only comes from mask modes with some bit set
  a_mask_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (mask_low_o != 64'd0 || mask_high_o != 64'd0)
      |-> match_index_o == 5'd0 && carry_flag_o)
    else $error("mask result inconsistent with index or carry");

  a_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_flag_o |-> carry_flag_o)
    else $error("overflow set without carry");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for packed_string_compare: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit  = 200000;
  localparam int NumRandom   = 1450;
  localparam int DrainCycles = 10;
  localparam int MaxGap      = 13;

  localparam logic [1:0] ModeExplIdx  = 2'd0;
  localparam logic [1:0] ModeExplMask = 2'd1;
  localparam logic [1:0] ModeImplIdx  = 2'd2;
  localparam logic [1:0] ModeImplMask = 2'd3;

  localparam logic [1:0] FmtUByte = 2'd0;
  localparam logic [1:0] FmtUWord = 2'd1;
  localparam logic [1:0] FmtSByte = 2'd2;
  localparam logic [1:0] FmtSWord = 2'd3;

  localparam logic [7:0] CtlIgnored = 8'h80;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         control;
    logic [63:0]        a_lo;
    logic [63:0]        a_hi;
    logic [63:0]        b_lo;
    logic [63:0]        b_hi;
    logic signed [31:0] len_a;
    logic signed [31:0] len_b;
  } cmp_req_t;

  typedef struct packed {
    logic [15:0] int_result;
    logic [4:0]  match_index;
    logic [63:0] mask_low;
    logic [63:0] mask_high;
    logic        carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
  } cmp_res_t;

  typedef struct packed {
    cmp_req_t req;
    logic     typed;
    cmp_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  cmp_req_t    cur_req = '0;
  logic        cur_typed = 1'b0;
  cmp_res_t    cur_exp = '0;

  logic        busy_o;
  logic        valid_o;
  logic [15:0] int_result_o;
  logic [4:0]  match_index_o;
  logic [63:0] mask_low_o;
  logic [63:0] mask_high_o;
  logic        carry_flag_o;
  logic        zero_flag_o;
  logic        sign_flag_o;
  logic        overflow_flag_o;

  cmp_res_t    pending_results[$];
  dir_row_t    dir_rows[$];
  int          error_count = 0;
  int          cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_string_compare u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy_o),
    .mode_i          (cur_req.mode),
    .control_i       (cur_req.control),
    .operand_a_low_i (cur_req.a_lo),
    .operand_a_high_i(cur_req.a_hi),
    .operand_b_low_i (cur_req.b_lo),
    .operand_b_high_i(cur_req.b_hi),
    .len_a_i         (cur_req.len_a),
    .len_b_i         (cur_req.len_b),
    .valid_o         (valid_o),
    .int_result_o    (int_result_o),
    .match_index_o   (match_index_o),
    .mask_low_o      (mask_low_o),
    .mask_high_o     (mask_high_o),
    .carry_flag_o    (carry_flag_o),
    .zero_flag_o     (zero_flag_o),
    .sign_flag_o     (sign_flag_o),
    .overflow_flag_o (overflow_flag_o)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] elem_key(logic [127:0] op, int i, bit words);
    if (words) return op[16*i +: 16];
    return {8'h00, op[8*i +: 8]};
  endfunction

  function automatic int null_len(logic [127:0] op, bit words, int n);
    int len;
    len = n;
    for (int i = n - 1; i >= 0; i--)
      if (elem_key(op, i, words) == 16'h0000) len = i;
    return len;
  endfunction

  function automatic int clamp_len(logic signed [31:0] len, int n);
    logic [31:0] mag;
    mag = len[31] ? (~len + 32'd1) : len;
    return (mag > 32'(n)) ? n : int'(mag);
  endfunction

  // One compare cell, with the override rules for elements past a string's end.
  function automatic bit cell_hit(psc_pkg::agg_e agg, bit a_ok, bit b_ok, logic [15:0] kb,
                                  logic [15:0] ka, bit upper);
    if (a_ok && b_ok) begin
      if (agg == psc_pkg::AggRanges) return upper ? (kb <= ka) : (kb >= ka);
      return kb == ka;
    end
    if (a_ok) return 1'b0;
    if (b_ok) return agg == psc_pkg::AggEqualOrdered;
    return (agg == psc_pkg::AggEqualEach) || (agg == psc_pkg::AggEqualOrdered);
  endfunction

  function automatic cmp_res_t predict_compare(cmp_req_t r);
    bit            words;
    bit            sel;
    int            n;
    int            la;
    int            lb;
    psc_pkg::agg_e agg;
    psc_pkg::pol_e pol;
    logic [15:0]   bias;
    logic [15:0]   full;
    logic [15:0]   ka [16];
    logic [15:0]   kb [16];
    logic [15:0]   hit;
    logic [15:0]   res;
    logic [127:0]  opa;
    logic [127:0]  opb;
    logic [127:0]  mask;
    bit            b;
    int            idx;
    cmp_res_t      o;
    words = r.control[0];
    sel   = r.control[6];
    n     = words ? 8 : 16;
    agg   = psc_pkg::agg_e'(r.control[3:2]);
    pol   = psc_pkg::pol_e'(r.control[5:4]);
    bias  = !r.control[1] ? 16'h0000 : (words ? 16'h8000 : 16'h0080);
    full  = words ? 16'h00FF : 16'hFFFF;
    opa   = {r.a_hi, r.a_lo};
    opb   = {r.b_hi, r.b_lo};
    for (int i = 0; i < 16; i++) begin
      ka[i] = '0;
      kb[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      ka[i] = elem_key(opa, i, words) ^ bias;
      kb[i] = elem_key(opb, i, words) ^ bias;
    end
    if (r.mode[1]) begin
      la = null_len(opa, words, n);
      lb = null_len(opb, words, n);
    end else begin
      la = clamp_len(r.len_a, n);
      lb = clamp_len(r.len_b, n);
    end

    hit = '0;
    for (int j = 0; j < n; j++) begin
      b = 1'b0;
      case (agg)
        psc_pkg::AggEqualAny: begin
          for (int i = 0; i < n; i++)
            b |= cell_hit(agg, i < la, j < lb, kb[j], ka[i], i[0]);
        end
        psc_pkg::AggRanges: begin
          for (int i = 0; i + 1 < n; i += 2)
            b |= cell_hit(agg, i < la, j < lb, kb[j], ka[i], 1'b0) &&
                 cell_hit(agg, i + 1 < la, j < lb, kb[j], ka[i+1], 1'b1);
        end
        psc_pkg::AggEqualEach: b = cell_hit(agg, j < la, j < lb, kb[j], ka[j], j[0]);
        default: begin
          b = 1'b1;
          for (int k = 0; k < n - j; k++)
            b &= cell_hit(agg, k < la, j + k < lb, kb[j+k], ka[k], k[0]);
        end
      endcase
      hit[j] = b;
    end

    case (pol)
      psc_pkg::PolNegative:  res = ~hit & full;
      psc_pkg::PolMaskedNeg: res = (hit ^ 16'((1 << lb) - 1)) & full;
      default:               res = hit;
    endcase

    // scan toward the wanted end so the last hit wins
    idx = n;
    if (sel) begin
      for (int i = 0; i < n; i++)
        if (res[i]) idx = i;
    end else begin
      for (int i = n - 1; i >= 0; i--)
        if (res[i]) idx = i;
    end

    mask = '0;
    if (r.mode[0]) begin
      if (sel) begin
        for (int i = 0; i < n; i++)
          if (res[i]) begin
            if (words) mask[16*i +: 16] = 16'hFFFF;
            else mask[8*i +: 8] = 8'hFF;
          end
      end else begin
        mask[15:0] = res;
      end
      idx = 0;
    end

    o.int_result    = res;
    o.match_index   = 5'(idx);
    o.mask_low      = mask[63:0];
    o.mask_high     = mask[127:64];
    o.carry_flag    = res != 16'h0000;
    o.zero_flag     = lb < n;
    o.sign_flag     = la < n;
    o.overflow_flag = res[0];
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] mk_ctl(logic [1:0] fmt, psc_pkg::agg_e agg,
                                        psc_pkg::pol_e pol, bit sel);
    return {1'b0, sel, pol, agg, fmt};
  endfunction

  function automatic cmp_req_t mk_req(logic [1:0] mode, logic [7:0] ctl,
                                      logic [63:0] alo, logic [63:0] ahi,
                                      logic [63:0] blo, logic [63:0] bhi,
                                      logic signed [31:0] la, logic signed [31:0] lb);
    cmp_req_t r;
    r = '{mode, ctl, alo, ahi, blo, bhi, la, lb};
    return r;
  endfunction

  function automatic cmp_res_t mk_res(logic [15:0] ir, logic [4:0] idx, logic [63:0] mlo,
                                      logic [63:0] mhi, bit cf, bit zf, bit sf, bit of);
    cmp_res_t r;
    r = '{ir, idx, mlo, mhi, cf, zf, sf, of};
    return r;
  endfunction

  task automatic add_row(cmp_req_t r, bit typed, cmp_res_t e);
    dir_row_t row;
    row.req   = r;
    row.typed = typed;
    row.res   = e;
    dir_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick_elem(bit words);
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, 3);
    if (roll < 6) return 16'h0000;
    if (roll < 55) return 16'h0061 + 16'(k);  // small alphabet so matches are common
    if (roll < 70) begin
      case (k)
        0:       return 16'h0001;
        1:       return words ? 16'h7FFF : 16'h007F;
        2:       return words ? 16'h8000 : 16'h0080;
        default: return words ? 16'hFFFF : 16'h00FF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_len(int n);
    int          roll;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      v = 32'($urandom_range(0, n + 2));
      return $urandom_range(0, 1) ? -v : v;
    end
    if (roll < 85) return $urandom;
    if (roll < 92) return 32'h8000_0000;
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'(n);
  endfunction

  function automatic logic [127:0] pack_elems(logic [15:0][15:0] e, bit words);
    logic [127:0] op;
    op = '0;
    for (int i = 0; i < 16; i++)
      if (words) begin
        if (i < 8) op[16*i +: 16] = e[i];
      end else begin
        op[8*i +: 8] = e[i][7:0];
      end
    return op;
  endfunction

  function automatic cmp_req_t rand_request();
    cmp_req_t          r;
    bit                words;
    int                n;
    int                plen;
    int                off;
    logic [15:0][15:0] ea;
    logic [15:0][15:0] eb;
    logic [127:0]      pa;
    logic [127:0]      pb;
    r.mode    = 2'($urandom_range(0, 3));
    r.control = 8'($urandom);
    words     = r.control[0];
    n         = words ? 8 : 16;
    if ($urandom_range(0, 99) < 10) begin
      // noise: fully random operands and lengths
      r.a_lo  = {$urandom, $urandom};
      r.a_hi  = {$urandom, $urandom};
      r.b_lo  = {$urandom, $urandom};
      r.b_hi  = {$urandom, $urandom};
      r.len_a = $urandom;
      r.len_b = $urandom;
      return r;
    end
    for (int i = 0; i < 16; i++) begin
      ea[i] = pick_elem(words);
      eb[i] = pick_elem(words);
    end
    // plant a prefix of the pattern inside the searched string, maybe cut off at the end
    if (psc_pkg::agg_e'(r.control[3:2]) == psc_pkg::AggEqualOrdered ||
        $urandom_range(0, 99) < 40) begin
      plen = $urandom_range(1, 4);
      off  = $urandom_range(0, n - 1);
      for (int k = 0; k < plen; k++)
        if (off + k < n) eb[off+k] = ea[k];
    end
    if ($urandom_range(0, 99) < 30) ea[$urandom_range(0, n - 1)] = '0;
    if ($urandom_range(0, 99) < 30) eb[$urandom_range(0, n - 1)] = '0;
    pa      = pack_elems(ea, words);
    pb      = pack_elems(eb, words);
    r.a_lo  = pa[63:0];
    r.a_hi  = pa[127:64];
    r.b_lo  = pb[63:0];
    r.b_hi  = pb[127:64];
    r.len_a = pick_len(n);
    r.len_b = pick_len(n);
    return r;
  endfunction

  function automatic int draw_gap(int item);
    // every fourth stretch of 100 requests runs back to back
    if ((item / 100) % 4 == 3) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // Holds start for one request until the block takes it.
  task automatic send_request(cmp_req_t r, bit typed, cmp_res_t e, int gap);
    for (int g = 0; g < gap; g++) begin
      @(negedge clk);
      start     <= 1'b0;
      cur_req   <= rand_request();
      cur_typed <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    cur_req   <= r;
    cur_typed <= typed;
    cur_exp   <= e;
    do @(posedge clk); while (busy_o !== 1'b0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cmp_res_t want;
    if (rst_n && valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request outstanding, expected none actual %h",
                 $time, int_result_o);
      end else begin
        want = pending_results.pop_front();
        check_field("int_result", 64'(want.int_result), 64'(int_result_o));
        check_field("match_index", 64'(want.match_index), 64'(match_index_o));
        check_field("mask_low", want.mask_low, mask_low_o);
        check_field("mask_high", want.mask_high, mask_high_o);
        check_field("carry_flag", 64'(want.carry_flag), 64'(carry_flag_o));
        check_field("zero_flag", 64'(want.zero_flag), 64'(zero_flag_o));
        check_field("sign_flag", 64'(want.sign_flag), 64'(sign_flag_o));
        check_field("overflow_flag", 64'(want.overflow_flag), 64'(overflow_flag_o));
      end
    end
    if (rst_n && start && busy_o === 1'b0)
      pending_results.push_back(cur_typed ? cur_exp : predict_compare(cur_req));
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL packed_string_compare");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int item;
    // all-null strings: nothing valid, so equal-any is empty and equal-each is full
    add_row(mk_req(ModeImplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualAny, psc_pkg::PolPositive, 1'b0),
                   '0, '0, '0, '0, 0, 0), 1'b1,
            mk_res(16'h0000, 5'd16, '0, '0, 1'b0, 1'b1, 1'b1, 1'b0));
    add_row(mk_req(ModeImplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualEach, psc_pkg::PolPositive, 1'b0),
                   '0, '0, '0, '0, 0, 0), 1'b1,
            mk_res(16'hFFFF, 5'd0, '0, '0, 1'b1, 1'b1, 1'b1, 1'b1));
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualEach, psc_pkg::PolPositive, 1'b1),
                   64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   64'hFFFF_0000_FFFF_0000, 64'h5555_AAAA_5555_AAAA, 0, 0), 1'b1,
            mk_res(16'hFFFF, 5'd0, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1));
    // full-length word strings that share nothing
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUWord, psc_pkg::AggEqualAny, psc_pkg::PolPositive, 1'b0),
                   64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
                   64'h2222_2222_2222_2222, 64'h2222_2222_2222_2222,
                   32'h8000_0000, -32'sd8), 1'b1,
            mk_res(16'h0000, 5'd8, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUWord, psc_pkg::AggEqualAny, psc_pkg::PolNegative, 1'b0),
                   64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
                   64'h2222_2222_2222_2222, 64'h2222_2222_2222_2222,
                   32'h7FFF_FFFF, -32'sd100), 1'b1,
            mk_res(16'h00FF, 5'd0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1));

    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualAny, psc_pkg::PolPositive, 1'b0),
                   64'h0000_0000_0063_6261, 64'hDEAD_BEEF_0000_0000,
                   64'h7A63_7962_7861_6162, 64'h6161_6262_6363_7878, 3, 16), 1'b0, '0);
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtUByte, psc_pkg::AggRanges, psc_pkg::PolPositive, 1'b0),
                   64'h0000_0000_0000_7A61, 64'h0,
                   64'h2041_7A61_6D30_5B60, 64'h7B7A_6160_4142_0000, 2, 10), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtSWord, psc_pkg::AggRanges, psc_pkg::PolPositive, 1'b1),
                   64'h0000_0000_0010_FF00, 64'h0,
                   64'h8000_0011_0010_FF00, 64'h7FFF_0000_FFFF_FEFF, 2, 8), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtSByte, psc_pkg::AggEqualEach, psc_pkg::PolPositive, 1'b0),
                   64'h8081_7F7E_0102_0304, 64'h1122_3344_5566_7788,
                   64'h8081_7F7E_0102_0504, 64'h1122_3344_5566_7788, 5, 9), 1'b0, '0);
    add_row(mk_req(ModeImplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualOrdered, psc_pkg::PolPositive, 1'b0),
                   64'h0000_0000_0000_6261, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h6261_7979_6261_7878, 64'h0, 0, 0), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualAny, psc_pkg::PolMaskedPos, 1'b0),
                   64'h0000_0000_0063_6261, 64'h0,
                   64'h7A63_7962_7861_6162, 64'h6161_6262_6363_7878, 4, 6), 1'b0, '0);
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualEach, psc_pkg::PolMaskedNeg, 1'b1),
                   64'h0807_0605_0403_0201, 64'h0,
                   64'h0807_0605_0499_0201, 64'h0, 3, 7), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualAny, psc_pkg::PolPositive, 1'b1),
                   64'h0000_0000_0063_6261, 64'h0,
                   64'h7A63_7962_7861_6162, 64'h6161_6262_6363_7878, 3, 16), 1'b0, '0);
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualOrdered, psc_pkg::PolPositive, 1'b0),
                   64'h0000_0000_0000_6261, 64'h0,
                   64'h6261_7979_6261_7878, 64'h6100_6261_0000_6162, 2, 16), 1'b0, '0);
    add_row(mk_req(ModeImplMask,
                   mk_ctl(FmtUWord, psc_pkg::AggEqualAny, psc_pkg::PolNegative, 1'b1),
                   64'h0000_0003_0002_0001, 64'h0,
                   64'h0004_0003_0002_0001, 64'h0001_0000_0005_0006, 0, 0), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtSByte, psc_pkg::AggEqualOrdered, psc_pkg::PolNegative, 1'b1)
                     | CtlIgnored,
                   64'h0000_0000_0000_6261, 64'h0,
                   64'h6261_7979_6261_7878, 64'h0, 2, -32'sd12), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualEach, psc_pkg::PolPositive, 1'b0),
                   64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10,
                   64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10,
                   -32'sd3, -32'sd16), 1'b0, '0);
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualAny, psc_pkg::PolMaskedNeg, 1'b1),
                   64'h0000_0000_0000_0041, 64'h0,
                   64'h4100_4100_4100_4100, 64'h0041_0041_0041_0041,
                   32'h8000_0000, 32'h8000_0000), 1'b0, '0);
    add_row(mk_req(ModeImplMask, 8'hFF, '1, '1, '1, '1, '1, '1), 1'b0, '0);
    add_row(mk_req(ModeImplIdx,
                   mk_ctl(FmtUWord, psc_pkg::AggEqualEach, psc_pkg::PolMaskedNeg, 1'b0),
                   64'h0001_0002_0003_0004, 64'h0001_0002_0003_0004,
                   64'h0001_0002_0003_0000, 64'h0001_0002_0003_0004, 0, 0), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualOrdered, psc_pkg::PolPositive, 1'b0),
                   64'h0000_0000_0000_6261, 64'h0,
                   64'h6261_7979_6261_7878, 64'h0, 0, 5), 1'b0, '0);
    add_row(mk_req(ModeExplIdx,
                   mk_ctl(FmtUByte, psc_pkg::AggEqualOrdered, psc_pkg::PolPositive, 1'b1),
                   64'h0000_0000_0000_6261, 64'h0,
                   64'h7878_7878_7878_7878, 64'h6100_0000_0000_0000, 2, 16), 1'b0, '0);
    add_row(mk_req(ModeExplMask,
                   mk_ctl(FmtSWord, psc_pkg::AggEqualAny, psc_pkg::PolPositive, 1'b0),
                   64'h8000_7FFF_0000_FFFF, 64'h0001_0002_0003_0004,
                   64'h7FFF_8001_8000_1234, 64'hFFFF_0000_0004_5555, 8, 8), 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    item = 0;
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res, draw_gap(item));
      item++;
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_request(rand_request(), 1'b0, '0, draw_gap(item));
      item++;
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS packed_string_compare");
    end else begin
      $display("FAIL packed_string_compare");
    end
    $finish;
  end

endmodule
